>>> rtl/spds_pkg.sv
`timescale 1ns / 1ps
package spds_pkg;
    localparam int MaxNodes   = 64;
    localparam int MaxEdges   = 256;
    localparam int WeightBits = 32;
    localparam int DistBits   = 40;
    localparam int CountBits  = 32;
    localparam int RankBits   = 6;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_RUN   = 2'd1,
        K_QUERY = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SOURCE = 2'd0,
        CFG_NODES  = 2'd1,
        CFG_EDGES  = 2'd2,
        CFG_DIR    = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN,
        S_PICK,
        S_EDGE_RD,
        S_EDGE_NODE,
        S_EDGE_DO,
        S_MARK_RD,
        S_MARK_NODE,
        S_MARK_DO,
        S_OUT_RD,
        S_OUT,
        S_QUERY_RD,
        S_QUERY
    } t_state;
endpackage

>>> rtl/spds_if.sv
`timescale 1ns / 1ps
interface spds_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         kind;
    logic [7:0]                         edge_index;
    logic [5:0]                         edge_from;
    logic [5:0]                         edge_to;
    logic [31:0]                        edge_weight;
    modport source (output valid, kind, edge_index, edge_from, edge_to, edge_weight,
                    input ready);
    modport sink   (input valid, kind, edge_index, edge_from, edge_to, edge_weight,
                    output ready);
endinterface

interface spds_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  node_id;
    logic [39:0] distance;
    logic [31:0] path_count;
    logic [5:0]  visit_rank;
    logic        edge_used;
    logic        last;
    modport source (output valid, node_id, distance, path_count, visit_rank, edge_used, last,
                    input ready);
    modport sink   (input valid, node_id, distance, path_count, visit_rank, edge_used, last,
                    output ready);
endinterface

>>> rtl/spds_ram.sv
`timescale 1ns / 1ps
module spds_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/shortest_path_dag_solver.sv
`timescale 1ns / 1ps
// Single-source shortest paths with path counting. Load items store edges in a
// slot memory; a run item first rewrites all MAX_NODES node entries, then
// settles nodes one at a time (least distance, lower id on ties). Each settle
// scans the N nodes and, for a reachable node, visits every edge slot: a read of
// the slot, then a node read and a relax step for the forward half and again for
// the backward half. A final pass marks edges on shortest paths (edge read, tail
// read, head read, mark write per edge), then N results come out, one per node,
// each waiting while the previous result is stalled. The steps are serialised by
// the single read port of the node and edge memories. No reset pass is needed:
// the node memory is rewritten at the start of every run, and a query reads a
// used mark only after a run and only for a slot below that run's edge count;
// every other slot reads as unused.
module shortest_path_dag_solver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    spds_in_if.sink     in_ch,
    spds_out_if.source  out_ch
);
    localparam int MAX_NODES   = spds_pkg::MaxNodes;
    localparam int MAX_EDGES   = spds_pkg::MaxEdges;
    localparam int WEIGHT_BITS = spds_pkg::WeightBits;
    localparam int DIST_BITS   = spds_pkg::DistBits;
    localparam int NB = $clog2(MAX_NODES);
    localparam int EB = $clog2(MAX_EDGES);
    localparam int CB = spds_pkg::CountBits;
    localparam int RB = spds_pkg::RankBits;
    localparam int NODE_W = DIST_BITS + CB + 1 + NB;
    localparam int EDGE_W = 12 + WEIGHT_BITS;
    localparam logic [DIST_BITS-1:0] DistInf = '1;
    localparam logic [DIST_BITS-1:0] DistSat = DistInf - 1'b1;

    // config
    logic [5:0] r_src;
    logic [6:0] r_ncnt;
    logic [8:0] r_ecnt;
    logic [1:0] r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src  <= '0;
            r_ncnt <= 7'd64;
            r_ecnt <= '0;
            r_dir  <= '0;
        end else if (i_cfg_we) begin
            unique case (spds_pkg::t_cfg_idx'(i_cfg_index))
                spds_pkg::CFG_SOURCE: r_src  <= i_cfg_data[5:0];
                spds_pkg::CFG_NODES:  r_ncnt <= i_cfg_data[6:0];
                spds_pkg::CFG_EDGES:  r_ecnt <= i_cfg_data;
                spds_pkg::CFG_DIR:    r_dir  <= i_cfg_data[1:0];
            endcase
        end
    end

    // effective counts
    logic [NB:0] n_eff;
    logic [EB:0] m_eff;
    always_comb begin
        if (r_ncnt == '0) n_eff = (NB+1)'(1);
        else if (32'(r_ncnt) > MAX_NODES) n_eff = (NB+1)'(MAX_NODES);
        else n_eff = (NB+1)'(r_ncnt);
        if (32'(r_ecnt) > MAX_EDGES) m_eff = (EB+1)'(MAX_EDGES);
        else m_eff = (EB+1)'(r_ecnt);
    end
    logic fwd, bwd;
    assign fwd = (r_dir != 2'd1);
    assign bwd = (r_dir != 2'd0);

    // memories
    logic              e_we, u_we, nd_we;
    logic [EB-1:0]     e_waddr, e_raddr, u_waddr, u_raddr;
    logic [EDGE_W-1:0] e_wdata, e_rdata;
    logic              u_wdata, u_rdata;
    logic [NB-1:0]     nd_waddr, nd_raddr;
    logic [NODE_W-1:0] nd_wdata, nd_rdata;

    spds_ram #(.Width(EDGE_W), .Depth(MAX_EDGES)) u_edge_ram (
        .i_clk, .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata));
    spds_ram #(.Width(1), .Depth(MAX_EDGES)) u_used_ram (
        .i_clk, .i_we(u_we), .i_waddr(u_waddr), .i_wdata(u_wdata),
        .i_raddr(u_raddr), .o_rdata(u_rdata));
    // node entry: {dist, count, settled, settle order}
    spds_ram #(.Width(NODE_W), .Depth(MAX_NODES)) u_node_ram (
        .i_clk, .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata));

    logic [DIST_BITS-1:0] rd_dist;
    logic [CB-1:0]        rd_cnt;
    logic                 rd_set;
    logic [NB-1:0]        rd_ord;
    assign {rd_dist, rd_cnt, rd_set, rd_ord} = nd_rdata;

    // edge entry: {tail, head, weight}
    logic [5:0] e_tail, e_head;
    assign e_head = e_rdata[WEIGHT_BITS +: 6];
    assign e_tail = e_rdata[WEIGHT_BITS + 6 +: 6];

    spds_pkg::t_state r_state, n_state;
    logic [NB:0]          r_i, n_i;      // node counter
    logic [NB:0]          r_rank, n_rank;
    logic [EB:0]          r_e, n_e;      // edge counter
    logic [EB:0]          r_mrun, n_mrun; // edge count of the last run
    logic [NB:0]          r_best, n_best;
    logic [DIST_BITS-1:0] r_bdist, n_bdist;
    logic [DIST_BITS-1:0] r_udist, n_udist;
    logic [CB-1:0]        r_ucnt, n_ucnt;
    logic [NB-1:0]        r_uord, n_uord;
    logic [NB-1:0]        r_u, n_u;
    logic [5:0]           r_t, n_t, r_h, n_h;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic                 r_phase, n_phase; // 0 forward half, 1 backward half
    logic                 r_used, n_used;
    logic                 r_ran, n_ran;
    logic                 r_qok, n_qok;
    logic                 r_ov, n_ov;
    logic [5:0]           r_oid, n_oid;
    logic [DIST_BITS-1:0] r_od, n_od;
    logic [CB-1:0]        r_oc, n_oc;
    logic [5:0]           r_ork, n_ork;
    logic                 r_oused, n_oused, r_olast, n_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spds_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_ran   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_ran   <= n_ran;
        end
        r_i <= n_i; r_rank <= n_rank; r_e <= n_e; r_mrun <= n_mrun; r_best <= n_best;
        r_bdist <= n_bdist; r_udist <= n_udist; r_ucnt <= n_ucnt; r_uord <= n_uord;
        r_u <= n_u; r_t <= n_t; r_h <= n_h; r_w <= n_w; r_phase <= n_phase;
        r_used <= n_used; r_qok <= n_qok; r_oid <= n_oid; r_od <= n_od; r_oc <= n_oc;
        r_ork <= n_ork; r_oused <= n_oused; r_olast <= n_olast;
    end

    // saturating add of a distance and a weight
    logic [DIST_BITS:0]   sum_w;
    logic [DIST_BITS-1:0] sat_s;
    logic [WEIGHT_BITS-1:0] w_eff;
    assign w_eff = (r_w == '0) ? WEIGHT_BITS'(1) : r_w;
    assign sum_w = {1'b0, r_udist} + (DIST_BITS+1)'(w_eff);
    assign sat_s = (r_udist > DistSat || sum_w > (DIST_BITS+1)'(DistSat)) ? DistSat
                   : sum_w[DIST_BITS-1:0];
    logic [CB:0] csum;
    assign csum = {1'b0, rd_cnt} + {1'b0, r_ucnt};

    // backward check: head distance plus weight against tail
    logic [DIST_BITS:0]   sum_hb;
    logic [DIST_BITS-1:0] sat_hb;
    assign sum_hb = {1'b0, rd_dist} + (DIST_BITS+1)'(w_eff);
    assign sat_hb = (rd_dist > DistSat || sum_hb > (DIST_BITS+1)'(DistSat)) ? DistSat
                    : sum_hb[DIST_BITS-1:0];

    // current edge endpoints for relax / mark
    logic [5:0] a_node, b_node;
    assign a_node = r_phase ? r_h : r_t;
    assign b_node = r_phase ? r_t : r_h;
    logic e_valid;
    assign e_valid = (7'(r_t) < 7'(n_eff)) && (7'(r_h) < 7'(n_eff));

    always_comb begin
        n_state = r_state; n_i = r_i; n_rank = r_rank; n_e = r_e; n_best = r_best;
        n_mrun = r_mrun;
        n_bdist = r_bdist; n_udist = r_udist; n_ucnt = r_ucnt; n_uord = r_uord;
        n_u = r_u; n_t = r_t; n_h = r_h; n_w = r_w; n_phase = r_phase; n_used = r_used;
        n_ran = r_ran; n_qok = r_qok; n_ov = r_ov; n_oid = r_oid; n_od = r_od;
        n_oc = r_oc; n_ork = r_ork; n_oused = r_oused; n_olast = r_olast;
        e_we = 1'b0; e_waddr = in_ch.edge_index[EB-1:0];
        e_wdata = {in_ch.edge_from, in_ch.edge_to, in_ch.edge_weight[WEIGHT_BITS-1:0]};
        e_raddr = r_e[EB-1:0];
        u_we = 1'b0; u_waddr = r_e[EB-1:0]; u_wdata = r_used;
        u_raddr = in_ch.edge_index[EB-1:0];
        nd_we = 1'b0; nd_waddr = r_i[NB-1:0]; nd_wdata = '0; nd_raddr = r_i[NB-1:0];
        in_ch.ready = 1'b0;
        if (out_ch.ready) n_ov = 1'b0;

        unique case (r_state)
            spds_pkg::S_IDLE: begin
                in_ch.ready = !r_ov;
                if (in_ch.valid && !r_ov) begin
                    unique case (spds_pkg::t_kind'(in_ch.kind))
                        spds_pkg::K_LOAD: begin
                            e_we = (32'(in_ch.edge_index) < MAX_EDGES);
                        end
                        spds_pkg::K_RUN: begin
                            n_i = '0;
                            n_mrun = m_eff;
                            n_state = spds_pkg::S_INIT;
                        end
                        spds_pkg::K_QUERY: begin
                            n_qok = (32'(in_ch.edge_index) < MAX_EDGES) && r_ran
                                    && ((EB+1)'(in_ch.edge_index) < r_mrun);
                            n_state = spds_pkg::S_QUERY;
                        end
                        spds_pkg::K_NONE: ;
                    endcase
                end
            end
            spds_pkg::S_INIT: begin
                nd_we = 1'b1;
                if (7'(r_i) == 7'(r_src) && 7'(r_src) < 7'(n_eff))
                    nd_wdata = {DIST_BITS'(0), CB'(1), 1'b0, NB'(0)};
                else
                    nd_wdata = {DistInf, CB'(0), 1'b0, NB'(0)};
                n_i = r_i + 1'b1;
                if (r_i == (NB+1)'(MAX_NODES - 1)) begin
                    n_rank = '0; n_i = '0; n_state = spds_pkg::S_SCAN_RD;
                end
            end
            spds_pkg::S_SCAN_RD: begin
                // issue read of node 0
                n_best = n_eff; n_bdist = DistInf;
                n_i = (NB+1)'(1);
                nd_raddr = '0;
                n_state = spds_pkg::S_SCAN;
            end
            spds_pkg::S_SCAN: begin
                // rd data belongs to node r_i-1
                if (!rd_set && (r_best == n_eff || rd_dist < r_bdist)) begin
                    n_best = r_i - 1'b1; n_bdist = rd_dist;
                    n_udist = rd_dist; n_ucnt = rd_cnt;
                end
                if (r_i == n_eff) begin
                    n_state = spds_pkg::S_PICK;
                end else begin
                    nd_raddr = r_i[NB-1:0];
                    n_i = r_i + 1'b1;
                end
            end
            spds_pkg::S_PICK: begin
                if (r_best >= n_eff) begin
                    n_e = '0; n_state = spds_pkg::S_MARK_RD;
                end else begin
                    nd_we = 1'b1; nd_waddr = r_best[NB-1:0];
                    nd_wdata = {r_udist, r_ucnt, 1'b1, r_rank[NB-1:0]};
                    n_u = r_best[NB-1:0];
                    n_rank = r_rank + 1'b1;
                    n_e = '0;
                    if (r_udist == DistInf || m_eff == '0) begin
                        n_state = (r_rank + 1'b1 == n_eff) ? spds_pkg::S_MARK_RD
                                  : spds_pkg::S_SCAN_RD;
                    end else begin
                        n_state = spds_pkg::S_EDGE_RD;
                    end
                end
            end
            spds_pkg::S_EDGE_RD: begin
                // edge data ready next cycle
                n_phase = 1'b0;
                n_state = spds_pkg::S_EDGE_NODE;
            end
            spds_pkg::S_EDGE_NODE: begin
                if (!r_phase) {n_t, n_h, n_w} = e_rdata;
                n_state = spds_pkg::S_EDGE_DO;
                // read partner node for this half
                if (!r_phase) begin
                    nd_raddr = e_head[NB-1:0];
                end else begin
                    nd_raddr = r_t[NB-1:0];
                end
            end
            spds_pkg::S_EDGE_DO: begin
                if (e_valid && (r_phase ? bwd : fwd) && a_node[NB-1:0] == r_u
                    && 7'(a_node) == 7'(r_u) && !rd_set) begin
                    nd_waddr = b_node[NB-1:0];
                    if (sat_s == rd_dist) begin
                        nd_we = 1'b1;
                        nd_wdata = {rd_dist, csum[CB] ? {CB{1'b1}} : csum[CB-1:0],
                                    rd_set, rd_ord};
                    end else if (sat_s < rd_dist) begin
                        nd_we = 1'b1;
                        nd_wdata = {sat_s, r_ucnt, rd_set, rd_ord};
                    end
                end
                if (!r_phase) begin
                    n_phase = 1'b1; n_state = spds_pkg::S_EDGE_NODE;
                end else begin
                    n_e = r_e + 1'b1;
                    e_raddr = n_e[EB-1:0];
                    if (n_e == m_eff) begin
                        // the next settle's edge pass, or the mark pass, starts again at slot 0
                        n_e = '0;
                        n_state = (r_rank == n_eff) ? spds_pkg::S_MARK_RD
                                  : spds_pkg::S_SCAN_RD;
                    end else begin
                        n_state = spds_pkg::S_EDGE_RD;
                    end
                end
            end
            spds_pkg::S_MARK_RD: begin
                if (r_e == m_eff) begin
                    n_ran = 1'b1; n_i = '0; n_state = spds_pkg::S_OUT_RD;
                end else begin
                    n_phase = 1'b0; n_used = 1'b0;
                    n_state = spds_pkg::S_MARK_NODE;
                end
            end
            spds_pkg::S_MARK_NODE: begin
                // load edge, read tail (a of forward half) then head
                if (!r_phase) begin
                    {n_t, n_h, n_w} = e_rdata;
                    nd_raddr = e_tail[NB-1:0];
                    n_phase = 1'b1;
                end else begin
                    nd_raddr = r_h[NB-1:0];
                    n_udist = rd_dist; n_uord = rd_ord;   // tail entry
                    n_state = spds_pkg::S_MARK_DO;
                end
            end
            spds_pkg::S_MARK_DO: begin
                // rd = head entry; r_udist/r_uord = tail entry
                if (e_valid) begin
                    if (fwd && r_udist != DistInf && r_uord < rd_ord && sat_s == rd_dist)
                        n_used = 1'b1;
                    if (bwd && rd_dist != DistInf && rd_ord < r_uord
                        && sat_hb == r_udist)
                        n_used = 1'b1;
                end
                u_we = 1'b1; u_wdata = n_used;
                n_e = r_e + 1'b1;
                e_raddr = n_e[EB-1:0];
                n_state = spds_pkg::S_MARK_RD;
            end
            spds_pkg::S_OUT_RD: begin
                nd_raddr = r_i[NB-1:0];
                if (!r_ov || out_ch.ready) n_state = spds_pkg::S_OUT;
            end
            spds_pkg::S_OUT: begin
                n_ov = 1'b1;
                n_oid = 6'(r_i); n_od = rd_dist; n_oc = rd_cnt; n_ork = 6'(rd_ord);
                n_oused = 1'b0;
                n_olast = (r_i + 1'b1 == n_eff);
                n_i = r_i + 1'b1;
                n_state = n_olast ? spds_pkg::S_IDLE : spds_pkg::S_OUT_RD;
            end
            spds_pkg::S_QUERY: begin
                if (!r_ov || out_ch.ready) begin
                    n_ov = 1'b1; n_oid = '0; n_od = '0; n_oc = '0; n_ork = '0;
                    n_oused = r_qok & u_rdata; n_olast = 1'b1;
                    n_state = spds_pkg::S_IDLE;
                end
            end
            default: n_state = spds_pkg::S_IDLE;
        endcase
    end

    assign out_ch.valid      = r_ov;
    assign out_ch.node_id    = r_oid;
    assign out_ch.distance   = r_od;
    assign out_ch.path_count = r_oc;
    assign out_ch.visit_rank = r_ork;
    assign out_ch.edge_used  = r_oused;
    assign out_ch.last       = r_olast;
endmodule

>>> rtl/spds_checker.sv
`timescale 1ns / 1ps
module spds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last,
    input logic        out_used,
    input logic [39:0] out_dist
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_dist))
        else $error("result dropped under stall");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !out_valid)
        else $error("item taken while result pending");
    a_used_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_used |-> out_last)
        else $error("used flag on run result");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result after reset");
endmodule

bind shortest_path_dag_solver spds_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last),
    .out_used(out_ch.edge_used), .out_dist(out_ch.distance));

>>> tb/shortest_path_dag_solver_test.sv
`timescale 1ns / 1ps
module shortest_path_dag_solver_test;
    localparam int          CycleLimit = 3000000;
    localparam logic [39:0] DistInf    = '1;
    localparam logic [39:0] DistSat    = DistInf - 40'd1;

    typedef struct packed {
        spds_pkg::t_kind kind;
        logic [7:0]  idx;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [31:0] weight;
    } t_edge_item;

    typedef struct packed {
        logic [5:0]  node_id;
        logic [39:0] distance;
        logic [31:0] path_count;
        logic [5:0]  visit_rank;
        logic        edge_used;
        logic        last;
    } t_node_report;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [8:0] i_cfg_data;

    spds_in_if  in_ch ();
    spds_out_if out_ch ();

    shortest_path_dag_solver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source)
    );

    // shadow of the block's registers and stores
    logic [5:0]  src_reg;
    logic [6:0]  nodes_reg;
    logic [8:0]  edges_reg;
    logic [1:0]  dir_reg;
    logic [5:0]  tail_mem [spds_pkg::MaxEdges];
    logic [5:0]  head_mem [spds_pkg::MaxEdges];
    logic [31:0] weight_mem [spds_pkg::MaxEdges];
    logic        used_mem [spds_pkg::MaxEdges];
    logic [39:0] dist_of [spds_pkg::MaxNodes];
    logic [31:0] paths_of [spds_pkg::MaxNodes];
    logic        settled [spds_pkg::MaxNodes];
    logic [5:0]  rank_of [spds_pkg::MaxNodes];
    int          order_of [spds_pkg::MaxNodes];

    t_edge_item   pending_items [$];
    t_node_report expected_reports [$];

    bit idle_on;
    bit hold_req;
    bit failed;
    int in_gap;
    int out_stall;
    int hold_left;
    int cycles;
    int item_total;

    function automatic logic [39:0] sat_sum(logic [39:0] d, logic [39:0] w);
        if (d > DistSat) return DistSat;
        if (w > DistSat - d) return DistSat;
        return d + w;
    endfunction

    function automatic void relax_edge(int u, int v, logic [39:0] w);
        logic [39:0] s;
        logic [32:0] c;
        if (settled[v]) return;
        s = sat_sum(dist_of[u], w);
        if (s == dist_of[v]) begin
            c = {1'b0, paths_of[v]} + {1'b0, paths_of[u]};
            paths_of[v] = c[32] ? '1 : c[31:0];
        end else if (s < dist_of[v]) begin
            dist_of[v] = s;
            paths_of[v] = paths_of[u];
        end
    endfunction

    function automatic bit edge_on_path(int a, int b, logic [39:0] w);
        if (dist_of[a] == DistInf) return 0;
        if (order_of[a] >= order_of[b]) return 0;
        return sat_sum(dist_of[a], w) == dist_of[b];
    endfunction

    function automatic void solve_paths();
        int n, m, u, t, h;
        bit fwd, bwd, used;
        logic [39:0] w;
        t_node_report rep;
        n = (nodes_reg == 0) ? 1
            : ((nodes_reg > spds_pkg::MaxNodes) ? spds_pkg::MaxNodes : int'(nodes_reg));
        m = (edges_reg > spds_pkg::MaxEdges) ? spds_pkg::MaxEdges : int'(edges_reg);
        fwd = dir_reg != 2'd1;
        bwd = dir_reg != 2'd0;
        for (int i = 0; i < spds_pkg::MaxNodes; i++) begin
            dist_of[i] = DistInf;
            paths_of[i] = 0;
            settled[i] = 0;
            rank_of[i] = 0;
            order_of[i] = 0;
        end
        for (int e = 0; e < spds_pkg::MaxEdges; e++) used_mem[e] = 0;
        if (src_reg < n) begin
            dist_of[src_reg] = 0;
            paths_of[src_reg] = 1;
        end
        for (int r = 0; r < n; r++) begin
            u = n;
            for (int i = 0; i < n; i++)
                if (!settled[i] && (u == n || dist_of[i] < dist_of[u])) u = i;
            if (u >= n) break;
            settled[u] = 1;
            rank_of[u] = r[5:0];
            order_of[u] = r;
            if (dist_of[u] == DistInf) continue;
            for (int e = 0; e < m; e++) begin
                t = tail_mem[e];
                h = head_mem[e];
                w = (weight_mem[e] == 0) ? 40'd1 : {8'd0, weight_mem[e]};
                if (t >= n || h >= n) continue;
                if (fwd && t == u) relax_edge(u, h, w);
                if (bwd && h == u) relax_edge(u, t, w);
            end
        end
        for (int e = 0; e < m; e++) begin
            t = tail_mem[e];
            h = head_mem[e];
            w = (weight_mem[e] == 0) ? 40'd1 : {8'd0, weight_mem[e]};
            if (t >= n || h >= n) continue;
            used = 0;
            if (fwd && edge_on_path(t, h, w)) used = 1;
            if (bwd && edge_on_path(h, t, w)) used = 1;
            used_mem[e] = used;
        end
        for (int i = 0; i < n; i++) begin
            rep.node_id = i[5:0];
            rep.distance = dist_of[i];
            rep.path_count = paths_of[i];
            rep.visit_rank = rank_of[i];
            rep.edge_used = 0;
            rep.last = (i + 1 == n);
            expected_reports.insert(expected_reports.size(), rep);
        end
    endfunction

    function automatic void apply_item(t_edge_item it);
        t_node_report rep;
        case (it.kind)
            spds_pkg::K_LOAD: begin
                tail_mem[it.idx] = it.from_node;
                head_mem[it.idx] = it.to_node;
                weight_mem[it.idx] = it.weight;
            end
            spds_pkg::K_RUN: solve_paths();
            spds_pkg::K_QUERY: begin
                rep = '0;
                rep.edge_used = used_mem[it.idx];
                rep.last = 1;
                expected_reports.insert(expected_reports.size(), rep);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_item(spds_pkg::t_kind k, int idx, int f, int t,
                                       logic [31:0] w);
        t_edge_item it;
        it.kind = k;
        it.idx = idx[7:0];
        it.from_node = f[5:0];
        it.to_node = t[5:0];
        it.weight = w;
        pending_items.insert(pending_items.size(), it);
        item_total++;
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom;
            2: return '1;
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    task automatic write_reg(spds_pkg::t_cfg_idx r, int value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= value[8:0];
        case (r)
            spds_pkg::CFG_SOURCE: src_reg = value[5:0];
            spds_pkg::CFG_NODES:  nodes_reg = value[6:0];
            spds_pkg::CFG_EDGES:  edges_reg = value[8:0];
            default:              dir_reg = value[1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int src, int n, int m, int dir);
        write_reg(spds_pkg::CFG_SOURCE, src);
        write_reg(spds_pkg::CFG_NODES, n);
        write_reg(spds_pkg::CFG_EDGES, m);
        write_reg(spds_pkg::CFG_DIR, dir);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_ch.valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.kind <= spds_pkg::K_LOAD;
            in_ch.edge_index <= '0;
            in_ch.edge_from <= '0;
            in_ch.edge_to <= '0;
            in_ch.edge_weight <= '0;
        end else if (!(in_ch.valid && !in_ch.ready)) begin
            if (in_ch.valid) begin
                apply_item(pending_items[0]);
                void'(pending_items.pop_front());
            end
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                in_gap = $urandom_range(0, 16);
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid <= 1'b1;
                in_ch.kind <= pending_items[0].kind;
                in_ch.edge_index <= pending_items[0].idx;
                in_ch.edge_from <= pending_items[0].from_node;
                in_ch.edge_to <= pending_items[0].to_node;
                in_ch.edge_weight <= pending_items[0].weight;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_node_report got;
        t_node_report want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.node_id = out_ch.node_id;
                got.distance = out_ch.distance;
                got.path_count = out_ch.path_count;
                got.visit_rank = out_ch.visit_rank;
                got.edge_used = out_ch.edge_used;
                got.last = out_ch.last;
                if (expected_reports.size() == 0) begin
                    failed = 1;
                    $display("%0t: unexpected item node %0d dist %h count %0d rank %0d %s",
                             $time, got.node_id, got.distance, got.path_count,
                             got.visit_rank,
                             $sformatf("used %b last %b", got.edge_used, got.last));
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        failed = 1;
                        $display("%0t: mismatch exp node %0d dist %h count %0d rank %0d %s",
                                 $time, want.node_id, want.distance, want.path_count,
                                 want.visit_rank,
                                 $sformatf("used %b last %b", want.edge_used, want.last));
                        $display("%0t:          got node %0d dist %h count %0d rank %0d %s",
                                 $time, got.node_id, got.distance, got.path_count,
                                 got.visit_rank,
                                 $sformatf("used %b last %b", got.edge_used, got.last));
                    end
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall = $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int n, m, src, e;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = spds_pkg::CFG_SOURCE;
        i_cfg_data = 0;
        idle_on = 1;
        src_reg = 0;
        nodes_reg = 7'd64;
        edges_reg = 0;
        dir_reg = 0;
        for (int i = 0; i < spds_pkg::MaxEdges; i++) used_mem[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ties, out-of-range edge end, zero weight, extremes of fields
        set_regs(0, 4, 5, 0);
        queue_item(spds_pkg::K_QUERY, 3, 0, 0, 0);
        queue_item(spds_pkg::K_LOAD, 0, 0, 1, 1);
        queue_item(spds_pkg::K_LOAD, 1, 0, 2, 1);
        queue_item(spds_pkg::K_LOAD, 2, 1, 3, 1);
        queue_item(spds_pkg::K_LOAD, 3, 2, 3, 0);
        queue_item(spds_pkg::K_LOAD, 4, 3, 9, 0);
        queue_item(spds_pkg::K_LOAD, 255, 63, 63, 32'hFFFF_FFFF);
        queue_item(spds_pkg::K_NONE, 170, 42, 21, 32'h5555_AAAA);
        queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 2, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 3, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 4, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 255, 0, 0, 0);
        wait_idle();
        set_regs(3, 4, 5, 1);
        queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 0, 0, 0, 0);
        wait_idle();
        set_regs(9, 4, 5, 3);
        queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 1, 0, 0, 0);
        wait_idle();
        set_regs(63, 0, 0, 2);
        queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
        wait_idle();

        // random graphs, small sizes
        item_total = 0;
        for (int ph = 0; item_total < 30; ph++) begin
            n = (ph % 2 == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            m = $urandom_range(0, 24);
            src = $urandom_range(0, n);
            if (src > 63) src = 63;
            set_regs(src, n, m, $urandom_range(0, 3));
            if (ph == 0) hold_req = 1;
            for (int i = 0; i < m; i++)
                queue_item(spds_pkg::K_LOAD, i, $urandom_range(0, n), $urandom_range(0, n),
                           pick_weight());
            for (int k = $urandom_range(2, 5); k > 0; k--) begin
                case ($urandom_range(0, 5))
                    0: queue_item(spds_pkg::K_NONE, $urandom, $urandom, $urandom, $urandom);
                    1: queue_item(spds_pkg::K_LOAD, $urandom_range(0, 255),
                                  $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                    2: queue_item(spds_pkg::K_QUERY, $urandom_range(0, 255), 0, 0, 0);
                    default: begin
                        queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
                        queue_item(spds_pkg::K_QUERY, $urandom_range(0, m), 0, 0, 0);
                    end
                endcase
            end
            queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
            queue_item(spds_pkg::K_QUERY, $urandom_range(0, 255), 0, 0, 0);
            wait_idle();
        end

        // full node range: ladder of unit-weight edges over nodes 0 to 21, the other nodes unreachable
        idle_on = 0;
        set_regs(0, 64, 40, 0);
        for (e = 0; e < 40; e++)
            queue_item(spds_pkg::K_LOAD, e, e / 2, e / 2 + 1 + e % 2, 1);
        queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 0, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 17, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 39, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 200, 0, 0, 0);
        wait_idle();
        set_regs(5, 127, 40, 3);
        queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 39, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 10, 0, 0, 0);
        wait_idle();
        set_regs(0, 100, 40, 2);
        queue_item(spds_pkg::K_RUN, 0, 0, 0, 0);
        queue_item(spds_pkg::K_QUERY, 19, 0, 0, 0);
        wait_idle();
        repeat (50) @(posedge i_clk);

        if (!failed && expected_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> shortest_path_dag_solver.f
rtl/spds_pkg.sv
rtl/spds_if.sv
rtl/spds_ram.sv
rtl/shortest_path_dag_solver.sv
rtl/spds_checker.sv
tb/shortest_path_dag_solver_test.sv
